@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the dither core; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside reset.
`define FSD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds on a rising edge outside reset.
`define FSD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define FSD_ASSERT(lbl, clk, rstn, prop, msg)
`define FSD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

@@ rtl/core/fsd_pkg.sv @@
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types, register indexes and the level quantizer of the dither core.
// ----------------------------------------------------------------------------
`default_nettype none

package fsd_pkg;

    // Configuration register indexes
    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_LEVEL_BITS = 1'b1;

    localparam int LINE_WIDTH_W = 13;
    localparam int LEVEL_BITS_W = 4;
    localparam int PIXEL_W      = 8;

    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 13'd640;
    localparam logic [LEVEL_BITS_W-1:0] LEVEL_BITS_RST = 4'd1;

    // Per-pixel position flags, produced with the column and carried with the pixel
    typedef struct packed {
        logic frame_start;
        logic first_row;
        logic last_col;
    } col_flags_t;

    // Keep the top bits of level and refill the low bits by repeating them.
    function automatic logic [7:0] quantize(input logic [7:0] level, input logic [3:0] bits);
        logic [7:0] kept;
        logic [7:0] res;
        logic [6:0] n;
        kept = level & (8'hFF << (4'd8 - bits));
        res  = kept;
        for (int i = 1; i <= 8; i++)
        begin
            n = 7'(i) * {3'b000, bits};
            if (n <= 7'd8)
            begin
                res = res | (kept >> n);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/fsd_line_store.sv @@
// ----------------------------------------------------------------------------
// fsd_line_store
// Next-row error memory: one write port, one registered read port that
// follows writes to the entry it holds.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd_line_store #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 18
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Capture a new entry, or refresh the held one when it is written.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr;
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
        else if (wr_en && (wr_addr == rd_addr_reg))
        begin
            rd_data_reg <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/fsd_col_ctrl.sv @@
// ----------------------------------------------------------------------------
// fsd_col_ctrl
// Column counter and first-row flag; gives the line-store address at input.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fsd_col_ctrl #(
    parameter int MAX_WIDTH = 4096,
    parameter int COL_W     = 12
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             step,
    input  wire logic                             frame_start,
    input  wire logic [fsd_pkg::LINE_WIDTH_W-1:0] line_width,
    output logic      [COL_W-1:0]                 col,
    output fsd_pkg::col_flags_t                   flags
);

    import fsd_pkg::*;

    localparam int WID_W = (COL_W + 1 > LINE_WIDTH_W) ? COL_W + 1 : LINE_WIDTH_W;

    logic [COL_W-1:0] column_count_reg;
    logic [COL_W-1:0] column_count_next;
    logic             first_row_reg;
    logic             first_row_next;
    logic [WID_W-1:0] width_raw;
    logic [WID_W-1:0] width_eff;
    logic             first_now;

    always_comb
    begin
        width_raw = WID_W'(line_width);
        if (width_raw == '0)
        begin
            width_eff = WID_W'(1);
        end
        else if (width_raw > WID_W'(MAX_WIDTH))
        begin
            width_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_raw;
        end
    end

    always_comb
    begin
        col               = frame_start ? '0 : column_count_reg;
        first_now         = frame_start | first_row_reg;
        flags.frame_start = frame_start;
        flags.first_row   = first_now;
        flags.last_col    = ((WID_W'(col) + WID_W'(1)) >= width_eff);
        if (flags.last_col)
        begin
            column_count_next = '0;
            first_row_next    = 1'b0;
        end
        else
        begin
            column_count_next = col + COL_W'(1);
            first_row_next    = first_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            first_row_reg    <= 1'b1;
        end
        else if (step)
        begin
            column_count_reg <= column_count_next;
            first_row_reg    <= first_row_next;
        end
    end

    `FSD_ASSERT(a_row_wraps, clk, rst_n, (step && flags.last_col) |=> (column_count_reg == '0), "column count did not wrap at row end")

endmodule

`default_nettype wire

@@ rtl/core/fsd_diffuse.sv @@
// ----------------------------------------------------------------------------
// fsd_diffuse
// Error add, clamp, round, quantize and Floyd-Steinberg share split; holds
// the right carry, the two next-row partials and the deferred row-end write.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fsd_diffuse #(
    parameter int FRAC_W = 8,
    parameter int COL_W  = 12
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             adv,
    input  wire logic [fsd_pkg::PIXEL_W-1:0]      pixel,
    input  wire logic [COL_W-1:0]                 col,
    input  wire fsd_pkg::col_flags_t              flags,
    input  wire logic [fsd_pkg::LEVEL_BITS_W-1:0] level_bits,
    input  wire logic [FRAC_W+9:0]                rd_data,
    output logic      [fsd_pkg::PIXEL_W-1:0]      q,
    output logic                                  wr_en,
    output logic      [COL_W-1:0]                 wr_addr,
    output logic      [FRAC_W+9:0]                wr_data
);

    import fsd_pkg::*;

    localparam int EW  = FRAC_W + 10;   // error word
    localparam int SW  = EW + 2;        // pixel plus error
    localparam int CW  = FRAC_W + 8;    // clamped sum
    localparam int PW  = EW + 3;        // error times weight
    localparam logic [CW-1:0] TOP  = {8'hFF, {FRAC_W{1'b0}}};
    localparam logic [CW:0]   HALF = (CW+1)'(1) << (FRAC_W - 1);

    logic signed [EW-1:0] right_carry_reg;
    logic signed [EW-1:0] below_left_reg;
    logic signed [EW-1:0] below_reg;
    logic                 pending_valid_reg;
    logic [COL_W-1:0]     pending_addr_reg;
    logic signed [EW-1:0] pending_data_reg;

    logic signed [EW-1:0] carry_eff;
    logic signed [EW-1:0] below_left_eff;
    logic signed [EW-1:0] below_eff;
    logic signed [EW-1:0] store_eff;
    logic signed [SW-1:0] sum;
    logic [CW-1:0]        clamped;
    logic [CW:0]          rounded;
    logic [3:0]           bits_eff;
    logic signed [EW-1:0] e;
    logic signed [PW-1:0] e_w;
    logic signed [EW-1:0] share1;
    logic signed [EW-1:0] share3;
    logic signed [EW-1:0] share5;
    logic signed [EW-1:0] share7;
    logic                 norm_we;

    // Divide by 16, truncating toward zero.
    function automatic logic signed [EW-1:0] sixteenth(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] biased;
        biased = p[PW-1] ? (p + PW'(15)) : p;
        return EW'(biased >>> 4);
    endfunction

    always_comb
    begin
        carry_eff      = flags.frame_start ? '0 : right_carry_reg;
        below_left_eff = flags.frame_start ? '0 : below_left_reg;
        below_eff      = flags.frame_start ? '0 : below_reg;
        // Row-end entry still waiting for its write slot
        if (flags.first_row)
        begin
            store_eff = '0;
        end
        else if (pending_valid_reg && (pending_addr_reg == col))
        begin
            store_eff = pending_data_reg;
        end
        else
        begin
            store_eff = $signed(rd_data);
        end

        sum = $signed(SW'({pixel, {FRAC_W{1'b0}}})) + SW'(carry_eff) + SW'(store_eff);
        if (sum[SW-1])
        begin
            clamped = '0;
        end
        else if (sum > $signed(SW'(TOP)))
        begin
            clamped = TOP;
        end
        else
        begin
            clamped = sum[CW-1:0];
        end
        rounded = {1'b0, clamped} + HALF;

        if (level_bits == '0)
        begin
            bits_eff = 4'd1;
        end
        else if (level_bits > 4'd8)
        begin
            bits_eff = 4'd8;
        end
        else
        begin
            bits_eff = level_bits;
        end
        q = quantize(rounded[CW-1:FRAC_W], bits_eff);

        e   = $signed(EW'(clamped)) - $signed(EW'({q, {FRAC_W{1'b0}}}));
        e_w = PW'(e);
        share1 = sixteenth(e_w);
        share3 = sixteenth(e_w * $signed(PW'(3)));
        share5 = sixteenth(e_w * $signed(PW'(5)));
        share7 = sixteenth(e_w * $signed(PW'(7)));

        norm_we = adv && (col != '0);
        if (norm_we)
        begin
            wr_en   = 1'b1;
            wr_addr = col - COL_W'(1);
            wr_data = below_left_eff + share3;
        end
        else
        begin
            wr_en   = pending_valid_reg;
            wr_addr = pending_addr_reg;
            wr_data = pending_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_carry_reg   <= '0;
            below_left_reg    <= '0;
            below_reg         <= '0;
            pending_valid_reg <= 1'b0;
        end
        else
        begin
            pending_valid_reg <= adv && flags.last_col;
            if (adv)
            begin
                if (flags.last_col)
                begin
                    right_carry_reg <= '0;
                    below_left_reg  <= '0;
                    below_reg       <= '0;
                end
                else
                begin
                    right_carry_reg <= share7;
                    below_left_reg  <= below_eff + share5;
                    below_reg       <= share1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && flags.last_col)
        begin
            pending_addr_reg <= col;
            pending_data_reg <= below_eff + share5;
        end
    end

    `FSD_ASSERT_NEVER(a_one_write, clk, rst_n, pending_valid_reg && norm_we, "row-end write collides with a column write")
    `FSD_ASSERT(a_pending_src, clk, rst_n, pending_valid_reg |-> $past(adv && flags.last_col), "row-end write without a row end")

endmodule

`default_nettype wire

@@ rtl/core/floyd_steinberg_dither_top.sv @@
// ----------------------------------------------------------------------------
// floyd_steinberg_dither_top
// Floyd-Steinberg error-diffusion ditherer for 8-bit grey pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Send pixels in raster order on the s_ group; s_tuser marks the first
//   pixel of a frame. Each request yields exactly one dithered pixel on the
//   m_ group, in order. Program line_width and level_bits through the cfg
//   port while no pixel is in flight.
// Timing:
//   The line store is read on the accept edge, the error add, quantize and
//   share split run in the compute stage, and the result lands in the output
//   register. One pixel is taken per cycle while the output is not stalled.
//   The single write port of the line store takes one entry per pixel; the
//   second row-end entry is written in the next cycle, when the first pixel
//   of a row never writes.
// Reset:
//   Control state clears, line_width returns to 640 and level_bits to 1.
//   The line store is not cleared; the first row of each frame ignores it.
// Stall:
//   When m_tready is low the output register holds its pixel, an empty
//   compute stage still takes one more request, and then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module floyd_steinberg_dither_top #(
    parameter int MAX_WIDTH           = 4096,
    parameter int ERROR_FRACTION_BITS = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input pixel stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] pixel_in
    input  wire logic                             s_tuser,   // [0] frame_start
    // output pixel stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [7:0]                       m_tdata,   // [7:0] pixel_out
    // configuration writes
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_index,
    input  wire logic [fsd_pkg::LINE_WIDTH_W-1:0] cfg_data
);

    import fsd_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW    = ERROR_FRACTION_BITS + 10;

    // configuration
    logic [LINE_WIDTH_W-1:0] line_width_reg;
    logic [LEVEL_BITS_W-1:0] level_bits_reg;

    // compute stage
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic [PIXEL_W-1:0]      s1_pixel_reg;
    logic [COL_W-1:0]        s1_col_reg;
    col_flags_t              s1_flags_reg;

    // output register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [PIXEL_W-1:0]      out_data_reg;

    logic                    accept;
    logic                    adv;
    logic                    out_free;
    logic [COL_W-1:0]        in_col;
    col_flags_t              in_flags;
    logic [EW-1:0]           rd_data;
    logic [PIXEL_W-1:0]      q;
    logic                    wr_en;
    logic [COL_W-1:0]        wr_addr;
    logic [EW-1:0]           wr_data;

    // Configuration registers: take a write on any edge with cfg_we high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RST;
            level_bits_reg <= LEVEL_BITS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LINE_WIDTH: line_width_reg <= cfg_data;
                REG_LEVEL_BITS: level_bits_reg <= cfg_data[LEVEL_BITS_W-1:0];
                default:        line_width_reg <= line_width_reg;
            endcase
        end
    end

    // Handshake: advance a loaded compute stage whenever the output register
    // frees up this cycle; take a request whenever the compute stage is empty or advances.
    always_comb
    begin
        out_free = !out_valid_reg || m_tready;
        adv      = s1_valid_reg && out_free;
        s_tready = !s1_valid_reg || adv;
        accept   = s_tvalid && s_tready;

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold while stalled.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= s_tdata;
            s1_col_reg   <= in_col;
            s1_flags_reg <= in_flags;
        end
        if (adv)
        begin
            out_data_reg <= q;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    fsd_col_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_col_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .frame_start (s_tuser),
        .line_width  (line_width_reg),
        .col         (in_col),
        .flags       (in_flags)
    );

    fsd_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (EW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (in_col),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    fsd_diffuse #(
        .FRAC_W (ERROR_FRACTION_BITS),
        .COL_W  (COL_W)
    ) u_diffuse (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .pixel      (s1_pixel_reg),
        .col        (s1_col_reg),
        .flags      (s1_flags_reg),
        .level_bits (level_bits_reg),
        .rd_data    (rd_data),
        .q          (q),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    `FSD_ASSERT_NEVER(a_no_overwrite, clk, rst_n, out_valid_reg && !m_tready && adv, "output register overwritten while stalled")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Floyd-Steinberg grey-level ditherer. Streams
// pixel requests through directed corner frames, a long row set wider than
// the store, a long output stall and randomized frames under several width and
// level settings. A bit-exact error-diffusion predictor checks every result.
// ----------------------------------------------------------------------------

module tb;

    localparam int LINE_STORE_DEPTH = 4096;
    localparam int ERR_FRAC         = 8;
    localparam int ERR_ONE          = 1 << ERR_FRAC;
    localparam int ERR_TOP          = 255 << ERR_FRAC;
    // Longest quiet span of a correct run is the output hold-off
    // plus one idle gap on each side; allow many times that.
    localparam int STALL_LIMIT      = 5000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WIDE_ROW_ITEMS   = 64;
    localparam int RANDOM_ITEMS     = 950;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] pixel_in
    logic        s_tuser;   // [0] frame_start
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] pixel_out
    logic        cfg_we;
    logic        cfg_index;
    logic [fsd_pkg::LINE_WIDTH_W-1:0] cfg_data;

    // Dithered levels still owed by the block, oldest first.
    logic [7:0] expected_pixels[$];

    // Predictor state: error-diffusion pipeline and register copies.
    int          row_err[LINE_STORE_DEPTH];
    bit          row_err_written[LINE_STORE_DEPTH];
    int          carry_right;
    int          part_below_left;
    int          part_below;
    int unsigned col_pos;
    bit          in_first_row;
    logic [12:0] width_reg;
    logic [3:0]  bits_reg;

    // Traffic shaping shared with the sink process.
    bit src_idle_on;
    bit sink_idle_on;
    int sink_hold_cycles;

    int mismatch_count;
    int stall_cycles;

    floyd_steinberg_dither_top #(
        .MAX_WIDTH          (LINE_STORE_DEPTH),
        .ERROR_FRACTION_BITS(ERR_FRAC)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Keep the top nb bits of a level and refill the rest by repeating them.
    function automatic logic [7:0] replicate_top_bits(input logic [7:0] lvl, input int nb);
        logic [7:0] kept;
        logic [7:0] res;
        int         sh;
        kept = lvl & (8'hFF << (8 - nb));
        res  = kept;
        for (sh = nb; sh <= 8; sh += nb)
        begin
            res = res | (kept >> sh);
        end
        return res;
    endfunction

    // Dither one accepted pixel and advance the diffusion state.
    function automatic logic [7:0] dither_pixel(input logic [7:0] pix, input logic fs);
        int         eff_width;
        int         nb;
        int         col_idx;
        int         pix_i;
        int         acc;
        int         lvl;
        int         q_i;
        int         qerr;
        logic [7:0] q;
        bit         row_end;

        eff_width = width_reg;
        if (eff_width < 1)
        begin
            eff_width = 1;
        end
        if (eff_width > LINE_STORE_DEPTH)
        begin
            eff_width = LINE_STORE_DEPTH;
        end
        nb = bits_reg;
        if (nb < 1)
        begin
            nb = 1;
        end
        if (nb > 8)
        begin
            nb = 8;
        end

        if (fs)
        begin
            col_pos         = 0;
            carry_right     = 0;
            part_below_left = 0;
            part_below      = 0;
            in_first_row    = 1'b1;
        end
        col_idx = col_pos % LINE_STORE_DEPTH;

        pix_i = pix;
        acc   = pix_i * ERR_ONE + carry_right;
        if (!in_first_row)
        begin
            acc += row_err[col_idx];
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > ERR_TOP)
        begin
            acc = ERR_TOP;
        end
        lvl = (acc + ERR_ONE / 2) / ERR_ONE;
        if (lvl > 255)
        begin
            lvl = 255;
        end
        q    = replicate_top_bits(lvl[7:0], nb);
        q_i  = q;
        qerr = acc - q_i * ERR_ONE;

        row_end = (col_idx + 1 >= eff_width);
        if (col_idx > 0)
        begin
            row_err[col_idx - 1]         = part_below_left + (qerr * 3) / 16;
            row_err_written[col_idx - 1] = 1'b1;
        end
        if (row_end)
        begin
            row_err[col_idx]         = part_below + (qerr * 5) / 16;
            row_err_written[col_idx] = 1'b1;
            carry_right              = 0;
            part_below_left          = 0;
            part_below               = 0;
            col_pos                  = 0;
            in_first_row             = 1'b0;
        end
        else
        begin
            carry_right     = (qerr * 7) / 16;
            part_below_left = part_below + (qerr * 5) / 16;
            part_below      = qerr / 16;
            col_pos         = col_idx + 1;
        end
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Shared driving helpers
    // ------------------------------------------------------------------------

    // Grey level with extra weight on black and white.
    function automatic logic [7:0] random_level();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return 8'd0;
        end
        if (pick == 1)
        begin
            return 8'd255;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Send one pixel request; called and returning at a falling edge.
    // s_tvalid stays high on return so back-to-back requests need no gap.
    task automatic send_pixel(input logic [7:0] pix, input logic fs);
        int          gap;
        logic        fs_sent;
        int unsigned next_col;
        gap      = src_idle_on ? $urandom_range(0, 13) : 0;
        fs_sent  = fs;
        next_col = col_pos % LINE_STORE_DEPTH;
        // Open a new frame rather than read a line-store entry never written.
        if (!fs && !in_first_row && !row_err_written[next_col])
        begin
            fs_sent = 1'b1;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= fs_sent;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        expected_pixels.push_back(dither_pixel(pix, fs_sent));
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        while (expected_pixels.size() > 0)
        begin
            @(negedge clk);
        end
    endtask

    // Drop the input, let the pipeline empty, then write both registers.
    task automatic configure(input logic [12:0] width_word, input logic [12:0] bits_word);
        s_tvalid <= 1'b0;
        wait_for_drain();
        // allow for the trailing row-end line-store write
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= fsd_pkg::REG_LINE_WIDTH;
        cfg_data  <= width_word;
        @(negedge clk);
        cfg_index <= fsd_pkg::REG_LEVEL_BITS;
        cfg_data  <= bits_word;
        @(negedge clk);
        cfg_we    <= 1'b0;
        width_reg = width_word;
        bits_reg  = bits_word[3:0];
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: width 640, one level bit, first row active without a
    // frame marker on the very first pixel.
    task automatic test_reset_defaults();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd127, 1'b0);
    endtask

    // One-pixel rows: every pixel ends a row. Width zero and level bits zero
    // must behave as one.
    task automatic test_narrow_rows();
        configure(13'd1, 13'd8);
        send_pixel(8'd200, 1'b1);
        send_pixel(8'd17, 1'b0);
        send_pixel(8'd255, 1'b0);
        configure(13'd0, 13'd0);
        send_pixel(8'd100, 1'b1);
        send_pixel(8'd255, 1'b0);
    endtask

    // Short rows with garbage above the level-bits field and a frame marker
    // landing mid-row.
    task automatic test_frame_restart();
        configure(13'd3, 13'h1FF3);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd90, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd31, 1'b1);
        send_pixel(8'd64, 1'b0);
        send_pixel(8'd250, 1'b0);
        send_pixel(8'd5, 1'b0);
    endtask

    // Shrink the width while the column already lies past it: the next pixel
    // must close the row. Level bits above eight act as eight at first.
    task automatic test_width_shrink();
        configure(13'd10, 13'd15);
        send_pixel(8'd180, 1'b1);
        send_pixel(8'd33, 1'b0);
        send_pixel(8'd77, 1'b0);
        send_pixel(8'd254, 1'b0);
        configure(13'd3, 13'd2);
        send_pixel(8'd129, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd140, 1'b0);
        send_pixel(8'd60, 1'b0);
        send_pixel(8'd222, 1'b0);
    endtask

    // Width above the store depth acts as the depth: run a long stretch of
    // one row back to back without a row end.
    task automatic test_full_width_row();
        int i;
        configure(13'h1FFF, 13'd5);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        for (i = 0; i < WIDE_ROW_ITEMS; i++)
        begin
            send_pixel(random_level(), i == 0);
        end
    endtask

    // Hold the output off for a long stretch while requests keep coming so
    // the block fills and stalls its input; then pause the input until the
    // block has emptied and carry on in the same frame.
    task automatic test_backpressure();
        int i;
        configure(13'd5, 13'd3);
        src_idle_on      = 1'b0;
        sink_idle_on     = 1'b0;
        sink_hold_cycles = LONG_HOLD_CYCLES;
        for (i = 0; i < 30; i++)
        begin
            send_pixel(random_level(), i == 0);
        end
        s_tvalid <= 1'b0;
        wait_for_drain();
        repeat (2) @(negedge clk);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (i = 0; i < 20; i++)
        begin
            send_pixel(random_level(), 1'b0);
        end
    endtask

    // Random phases: new width and level setting each time, mostly whole
    // frames of random content, some phases continuing the previous frame
    // across the width change, and occasional stray frame markers.
    task automatic test_random_frames(input int item_target);
        int          sent;
        int          phase_len;
        int          i;
        int          pick;
        int          w;
        logic [12:0] bits_word;
        logic        fs;
        sent = 0;
        while (sent < item_target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                w = $urandom_range(1, 16);
            end
            else if (pick < 80)
            begin
                w = $urandom_range(17, 64);
            end
            else if (pick < 92)
            begin
                w = $urandom_range(65, 300);
            end
            else if (pick < 96)
            begin
                w = 0;
            end
            else
            begin
                w = $urandom_range(4097, 8191);
            end
            bits_word      = 13'($urandom_range(0, 511)) << 4;
            bits_word[3:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                         : 4'($urandom_range(1, 8));
            configure(13'(w), bits_word);
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            phase_len    = $urandom_range(30, 120);
            for (i = 0; i < phase_len; i++)
            begin
                fs = (i == 0 && $urandom_range(0, 3) != 0)
                     || (col_pos == 0 && $urandom_range(0, 9) == 0)
                     || ($urandom_range(0, 49) == 0);
                send_pixel(random_level(), fs);
            end
            sent += phase_len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: sink with random stalls, checker, watchdog
    // ------------------------------------------------------------------------

    // Accept one result per pass; draw a stall before each when sink_idle_on
    // is set, and take a long hold-off whenever a test asks for one.
    initial
    begin : result_sink
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (sink_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (sink_hold_cycles) @(negedge clk);
                sink_hold_cycles = 0;
            end
            gap = sink_idle_on ? $urandom_range(0, 13) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            @(negedge clk);
        end
    end

    // Compare each delivered pixel with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        logic [7:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("pixel_out %0d delivered with no request outstanding", m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (m_tdata !== want)
                begin
                    $error("pixel_out mismatch: expected %0d, actual %0d", want, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort when nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = 8'd0;
        s_tuser          = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = fsd_pkg::REG_LINE_WIDTH;
        cfg_data         = '0;
        mismatch_count   = 0;
        stall_cycles     = 0;
        sink_hold_cycles = 0;
        src_idle_on      = 1'b0;
        sink_idle_on     = 1'b0;
        // predictor state after reset
        carry_right      = 0;
        part_below_left  = 0;
        part_below       = 0;
        col_pos          = 0;
        in_first_row     = 1'b1;
        width_reg        = 13'd640;
        bits_reg         = 4'd1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_narrow_rows();
        test_frame_restart();
        test_width_shrink();
        test_full_width_row();
        test_backpressure();
        test_random_frames(RANDOM_ITEMS);

        // drain and give a stray extra result time to show up
        s_tvalid <= 1'b0;
        wait_for_drain();
        repeat (8) @(negedge clk);

        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
